// File: sv/assert_macros.svh
// Assertion macros shared by the date conversion RTL.
// Included by the top level; expects a clock named i_clk and a reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside of reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after a reset cycle.
`define ASSERT_AFTER_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dsc_pkg.sv
// Types and constants for the date to day and second count converter.
// No dependencies; used by all modules.
`default_nettype none

package dsc_pkg;

    // Year plus 32768 plus 131 gives ceil-division input (y + 32800 + 99) for base 100.
    localparam logic [16:0] C_CENTURY_OFFSET = 17'd131;
    // Reciprocal of 100 scaled by 2**23, exact for dividends below 91180.
    localparam logic [16:0] C_RECIP_100      = 17'd83887;
    localparam int          C_RECIP_SHIFT    = 23;
    // Quotient bias: 32800 / 100.
    localparam logic [10:0] C_QUOT_BIAS      = 11'd328;
    localparam logic [6:0]  C_CENTURY_REM    = 7'd99;
    // Weekday bias: offset 5 plus 7 * 2**21 keeps the sum non-negative.
    localparam logic [24:0] C_WEEKDAY_BIAS   = 25'd14680069;
    localparam logic [3:0]  C_WEEK_LEN       = 4'd7;
    // 86400 = 675 * 128.
    localparam logic signed [34:0] C_SECS_DAY_ODD = 35'sd675;
    localparam int          C_SECS_DAY_SHIFT = 7;

    localparam logic [3:0]  C_MONTH_JAN      = 4'd1;
    localparam logic [3:0]  C_MONTH_FEB      = 4'd2;
    localparam logic [3:0]  C_MONTH_DEC      = 4'd12;

    // Payload passed from the day number stages to the second count stages.
    typedef struct packed {
        logic signed [24:0] day_number;
        logic [19:0]        day;
        logic               period_mode;
        logic [16:0]        hms_seconds;
    } t_mid;

    // Days in the year before the first day of the given month (1 to 12).
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

// File: sv/dsc_if.sv
// Valid/ready channel interfaces for the date input and the converted result.
// Depends on nothing but plain logic types.
`default_nettype none

interface dsc_date_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [19:0]        day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic               period_mode;

    modport source (output valid, year, month, day, hour, minute, second, period_mode,
                    input ready);
    modport sink   (input valid, year, month, day, hour, minute, second, period_mode,
                    output ready);
endinterface

interface dsc_result_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] day_number;
    logic signed [41:0] total_seconds;
    logic [2:0]         weekday;

    modport source (output valid, day_number, total_seconds, weekday, input ready);
    modport sink   (input valid, day_number, total_seconds, weekday, output ready);
endinterface

`default_nettype wire

// File: sv/date_to_day_and_second_count.sv
// Converts a proleptic Gregorian date and time into a day number counted from
// 1 January of year 0, a total second count and a weekday (0 Monday to 6 Sunday).
// The block is a five-stage pipeline that takes one date per clock cycle while
// the output side is ready, and each date is registered in stages one to five
// in order. Each stage holds its own valid bit, so a stall on the result channel
// backs up stage by stage without losing or repeating a transfer, and the input
// keeps flowing until every stage is full. The stage depth is set by the
// reciprocal multiply that divides the year by 100 and by the 25 by 10 bit
// multiply of the day count by 675. In period mode the raw day field, not the
// day number, feeds the second count; the day number and weekday always come
// from the calendar fields. Months below January read as January and months
// above December read as December.
`default_nettype none

`include "assert_macros.svh"

module date_to_day_and_second_count (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dsc_date_if.sink     i_date,
    dsc_result_if.source o_result
);

    // Link between the day number stages and the second count stages.
    logic          mid_valid;
    logic          mid_ready;
    dsc_pkg::t_mid mid;

    // Stages one to three compute the leap count and the day number.
    dsc_day_calc u_day_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_date      (i_date),
        .o_mid_valid (mid_valid),
        .i_mid_ready (mid_ready),
        .o_mid       (mid)
    );

    // Stages four and five scale the day count to seconds and reduce modulo seven.
    dsc_sec_calc u_sec_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .o_mid_ready (mid_ready),
        .i_mid       (mid),
        .o_result    (o_result)
    );

    // A ready output side lets every stage advance, so the input must be ready too.
    `ASSERT_IMPLIES(a_ready_flows_back, o_result.ready, i_date.ready, "input stalled while output ready")
    // The residue logic never yields a weekday code of seven.
    `ASSERT_IMPLIES(a_weekday_range, o_result.valid, o_result.weekday <= 3'd6, "weekday out of range")
    // Reset empties the pipeline at both the middle link and the output.
    `ASSERT_AFTER_RESET(a_reset_empties, !o_result.valid && !mid_valid, "pipeline not empty after reset")

endmodule

`default_nettype wire

// File: sv/dsc_day_calc.sv
// Stages one to three: year scaling, leap year count and day number.
// Depends on dsc_pkg and dsc_date_if.
`default_nettype none

module dsc_day_calc (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dsc_date_if.sink    i_date,
    output logic        o_mid_valid,
    input  wire logic   i_mid_ready,
    output dsc_pkg::t_mid o_mid
);

    logic en1, en2, en3;

    // Stage 1 registers.
    logic               r_v1;
    logic [10:0]        r_quot100;
    logic [16:0]        r_div_arg;
    logic signed [24:0] r_year_days;
    logic signed [14:0] r_q4;
    logic               r_y_div4;
    logic [8:0]         r_dbm;
    logic               r_early;
    logic [19:0]        r_day1;
    logic               r_period1;
    logic [16:0]        r_hms1;

    // Stage 2 registers.
    logic               r_v2;
    logic signed [14:0] r_lb;
    logic               r_adj;
    logic signed [24:0] r_part;
    logic [19:0]        r_day2;
    logic               r_period2;
    logic [16:0]        r_hms2;

    // Stage 3 registers.
    logic               r_v3;
    dsc_pkg::t_mid      r_mid;

    assign en3 = !r_v3 || i_mid_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_date.ready = en1;

    // Stage 1 logic.
    logic [15:0]        year_bias;
    logic [16:0]        div_arg;
    logic [33:0]        div_prod;
    logic signed [24:0] year_days;
    logic signed [16:0] year_p3;
    logic signed [14:0] n_q4;
    logic [3:0]         month_c;
    logic [16:0]        n_hms;

    assign year_bias = {~i_date.year[15], i_date.year[14:0]};
    assign div_arg   = {1'b0, year_bias} + dsc_pkg::C_CENTURY_OFFSET;
    assign div_prod  = 34'(div_arg) * 34'(dsc_pkg::C_RECIP_100);
    assign year_days = $signed(25'(i_date.year)) * 25'sd365;
    assign year_p3   = $signed(17'(i_date.year)) + 17'sd3;
    assign n_q4      = 15'(year_p3 >>> 2);
    assign n_hms     = 17'(i_date.hour) * 17'd3600 + 17'(i_date.minute) * 17'd60
                     + 17'(i_date.second);

    always_comb begin
        if (i_date.month < dsc_pkg::C_MONTH_JAN) begin
            month_c = dsc_pkg::C_MONTH_JAN;
        end else if (i_date.month > dsc_pkg::C_MONTH_DEC) begin
            month_c = dsc_pkg::C_MONTH_DEC;
        end else begin
            month_c = i_date.month;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_date.valid;
        end
        if (en1) begin
            r_quot100   <= div_prod[dsc_pkg::C_RECIP_SHIFT +: 11];
            r_div_arg   <= div_arg;
            r_year_days <= year_days;
            r_q4        <= n_q4;
            r_y_div4    <= (i_date.year[1:0] == 2'b00);
            r_dbm       <= dsc_pkg::days_before_month(month_c);
            r_early     <= (month_c <= dsc_pkg::C_MONTH_FEB);
            r_day1      <= i_date.day;
            r_period1   <= i_date.period_mode;
            r_hms1      <= n_hms;
        end
    end

    // Stage 2 logic: ceil(y/100) and ceil(y/400) give the leap count before the year.
    logic [16:0]        rem_full;
    logic               century;
    logic signed [10:0] q100;
    logic signed [11:0] q100_p3;
    logic signed [9:0]  q400;
    logic signed [14:0] n_lb;
    logic               leap;
    logic signed [24:0] n_part;

    assign rem_full = r_div_arg - 17'(r_quot100) * 17'd100;
    assign century  = (rem_full[6:0] == dsc_pkg::C_CENTURY_REM);
    assign q100     = $signed(r_quot100 - dsc_pkg::C_QUOT_BIAS);
    assign q100_p3  = $signed(12'(q100)) + 12'sd3;
    assign q400     = 10'(q100_p3 >>> 2);
    assign n_lb     = r_q4 - $signed(15'(q100)) + $signed(15'(q400));
    assign leap     = r_y_div4 && (!century || (q100[1:0] == 2'b00));
    assign n_part   = r_year_days + $signed({16'b0, r_dbm}) + $signed({5'b0, r_day1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2) begin
            r_lb      <= n_lb;
            r_adj     <= r_early || !leap;
            r_part    <= n_part;
            r_day2    <= r_day1;
            r_period2 <= r_period1;
            r_hms2    <= r_hms1;
        end
    end

    // Stage 3 logic: final day number.
    logic signed [24:0] n_day_number;

    assign n_day_number = r_part + $signed(25'(r_lb)) - $signed({24'b0, r_adj});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
        if (en3) begin
            r_mid.day_number  <= n_day_number;
            r_mid.day         <= r_day2;
            r_mid.period_mode <= r_period2;
            r_mid.hms_seconds <= r_hms2;
        end
    end

    assign o_mid_valid = r_v3;
    assign o_mid       = r_mid;

endmodule

`default_nettype wire

// File: sv/dsc_sec_calc.sv
// Stages four and five: second count and weekday, with the output register.
// Depends on dsc_pkg and dsc_result_if.
`default_nettype none

module dsc_sec_calc (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_mid_valid,
    output logic         o_mid_ready,
    input  wire dsc_pkg::t_mid i_mid,
    dsc_result_if.source o_result
);

    logic en4, en5;

    logic               r_v4;
    logic signed [34:0] r_prod;
    logic [5:0]         r_wsum;
    logic signed [24:0] r_daynum4;
    logic [16:0]        r_hms4;

    logic               r_v5;
    logic signed [24:0] r_day_number;
    logic signed [41:0] r_secs;
    logic [2:0]         r_weekday;

    assign en5 = !r_v5 || o_result.ready;
    assign en4 = !r_v4 || en5;
    assign o_mid_ready = en4;

    // Stage 4: day count times 675, and the octal digit sum for the weekday (8 is 1 mod 7).
    logic signed [24:0] count;
    logic signed [34:0] n_prod;
    logic [24:0]        wd_arg;
    logic [5:0]         n_wsum;

    assign count  = i_mid.period_mode ? $signed({5'b0, i_mid.day}) : i_mid.day_number;
    assign n_prod = $signed(35'(count)) * dsc_pkg::C_SECS_DAY_ODD;
    assign wd_arg = $unsigned(i_mid.day_number) + dsc_pkg::C_WEEKDAY_BIAS;

    always_comb begin
        n_wsum = 6'(wd_arg[24]);
        for (int k = 0; k < 8; k++) begin
            n_wsum = n_wsum + 6'(wd_arg[3*k +: 3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en4) begin
            r_v4 <= i_mid_valid;
        end
        if (en4) begin
            r_prod    <= n_prod;
            r_wsum    <= n_wsum;
            r_daynum4 <= i_mid.day_number;
            r_hms4    <= i_mid.hms_seconds;
        end
    end

    // Stage 5: finish the residue and the second count.
    logic [3:0]         fold1;
    logic [3:0]         fold2;
    logic [2:0]         n_weekday;
    logic signed [41:0] n_secs;

    assign fold1     = 4'(r_wsum[5:3]) + 4'(r_wsum[2:0]);
    assign fold2     = 4'(fold1[3]) + 4'(fold1[2:0]);
    assign n_weekday = (fold2 >= dsc_pkg::C_WEEK_LEN) ? 3'(fold2 - dsc_pkg::C_WEEK_LEN)
                                                      : fold2[2:0];
    assign n_secs    = $signed({r_prod, {dsc_pkg::C_SECS_DAY_SHIFT{1'b0}}})
                     + $signed({25'b0, r_hms4});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en5) begin
            r_v5 <= r_v4;
        end
        if (en5) begin
            r_day_number <= r_daynum4;
            r_secs       <= n_secs;
            r_weekday    <= n_weekday;
        end
    end

    assign o_result.valid         = r_v5;
    assign o_result.day_number    = r_day_number;
    assign o_result.total_seconds = r_secs;
    assign o_result.weekday       = r_weekday;

endmodule

`default_nettype wire
